// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Severity priority queue package
// Shared types, operation codes and helper functions for the queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Operation codes carried on the input tuser.
	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_POP    = 2'd1,
		KIND_PEEK   = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_WALK,
		ST_PLACE,
		ST_RESULT
	} state_t;

	// One stored entry: 23 bits.
	typedef struct packed {
		logic [7:0]  tag;
		logic [3:0]  prio;
		logic [10:0] mins;
	} entry_t;

	// Result of one operation, held until the output register is free.
	typedef struct packed {
		logic   found;
		logic   full_res;
		entry_t head;
	} result_t;

	localparam logic [4:0] HOURS_HALF_DAY = 5'd12;

	// Converts a 12-hour clock time to minutes since midnight.
	// Hour times 60 is built as hour times 64 minus hour times 4.
	function automatic logic [10:0] to_minutes(input logic [3:0] hour,
						   input logic [5:0] minute,
						   input logic       pm);
		logic [4:0] h;
		h = {1'b0, hour};
		if (pm) begin
			if (h != HOURS_HALF_DAY)
				h = h + HOURS_HALF_DAY;
		end else begin
			if (h == HOURS_HALF_DAY)
				h = '0;
		end
		return 11'({h, 6'b0}) - 11'({h, 2'b0}) + 11'(minute);
	endfunction

	// True if the new entry must stand ahead of the stored one.
	function automatic logic goes_before(input entry_t nw, input entry_t old);
		if (nw.prio != old.prio)
			return nw.prio > old.prio;
		return nw.mins < old.mins;
	endfunction

endpackage

// ===== rtl/core/severity_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Severity priority queue unit
// Sorted-list priority queue held in a circular buffer in one synchronous RAM.
// ----------------------------------------------------------------------------
// Entries are kept in a circular buffer in on-chip RAM, sorted with the head
// (highest priority, earliest time within a priority) at the head pointer. For
// a pop or peek the head address goes to the RAM as the beat is taken, the
// entry read back is held as the result, and the result is then loaded into
// the output register. An insert walks back from the tail one entry per cycle
// through the RAM, moving each entry that must stand behind the new one down
// by a slot; an insert into an empty or a full queue does not walk. Under
// back-pressure on the output the result waits in the result state. One
// operation is worked on at a time; a new input beat is taken as soon as the
// sequencer is back in idle, even while the previous result still waits on
// the output.
module severity_priority_queue_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: entry_tag[7:0], clock_hour[11:8], clock_minute[17:12],
	//        is_pm[18], priority_req[22:19], zero pad[23]
	input  logic [23:0] s_axis_tdata,
	// tuser: kind[1:0]
	input  logic [1:0]  s_axis_tuser,
	// Output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: head_tag[7:0], head_priority[11:8], head_minutes[22:12],
	//        occupancy[27:23], zero pad[31:28]
	output logic [31:0] m_axis_tdata,
	// tuser: found[0], full_res[1]
	output logic [1:0]  m_axis_tuser
);
	import spq_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	// Circular pointer stepping with wrap at the buffer depth.
	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		if (p == LAST_PTR)
			return '0;
		return p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		if (p == '0)
			return LAST_PTR;
		return p - 1'b1;
	endfunction

	state_t          state_q, state_d;
	kind_t           kind_q;
	kind_t           in_kind;
	entry_t          in_entry;
	entry_t          new_q;
	entry_t          rd_data_q;
	entry_t          mem [QUEUE_DEPTH];
	result_t         res_q, res_d;
	logic [PW-1:0]   head_q, tail_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   rd_ptr_q, wr_ptr_q;
	logic [PW-1:0]   lvl_q;
	logic            out_valid_q;
	logic [31:0]     out_data_q;
	logic [1:0]      out_user_q;

	logic            accept;
	logic            mem_we;
	logic [PW-1:0]   mem_waddr, mem_raddr;
	entry_t          mem_wdata;
	logic            ld_res, ld_walk, step_walk, do_push, do_pop, ld_out;

	// Unpack the input beat and convert the clock time.
	assign in_kind        = kind_t'(s_axis_tuser);
	assign in_entry.tag   = s_axis_tdata[7:0];
	assign in_entry.prio  = s_axis_tdata[22:19];
	assign in_entry.mins  = to_minutes(s_axis_tdata[11:8], s_axis_tdata[17:12],
					   s_axis_tdata[18]);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Entry RAM: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_data_q <= mem[mem_raddr];
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state, RAM controls and datapath strobes.
	// The walk writes slot i+1 while it reads slot i-1; these never coincide
	// on a read whose data is used, so no forwarding path is needed.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = wr_ptr_q;
		mem_wdata = new_q;
		mem_raddr = rd_ptr_q;
		ld_res    = 1'b0;
		res_d     = '0;
		ld_walk   = 1'b0;
		step_walk = 1'b0;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		ld_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_kind)
						KIND_INSERT: begin
							if (count_q == FULL_CNT) begin
								ld_res         = 1'b1;
								res_d.full_res = 1'b1;
								state_d        = ST_RESULT;
							end else if (count_q == '0) begin
								mem_we    = 1'b1;
								mem_waddr = tail_q;
								mem_wdata = in_entry;
								do_push   = 1'b1;
								ld_res    = 1'b1;
								state_d   = ST_RESULT;
							end else begin
								mem_raddr = ptr_dec(tail_q);
								ld_walk   = 1'b1;
								state_d   = ST_WALK;
							end
						end
						KIND_POP, KIND_PEEK: begin
							if (count_q != '0) begin
								mem_raddr = head_q;
								state_d   = ST_HEAD;
							end else begin
								ld_res  = 1'b1;
								state_d = ST_RESULT;
							end
						end
						default: begin
							ld_res  = 1'b1;
							state_d = ST_RESULT;
						end
					endcase
				end
			end
			ST_HEAD: begin
				ld_res      = 1'b1;
				res_d.found = 1'b1;
				res_d.head  = rd_data_q;
				do_pop      = (kind_q == KIND_POP);
				state_d     = ST_RESULT;
			end
			ST_WALK: begin
				mem_we = 1'b1;
				if (goes_before(new_q, rd_data_q)) begin
					// Move the stored entry down one slot and look further up.
					mem_wdata = rd_data_q;
					step_walk = 1'b1;
					if (lvl_q == '0)
						state_d = ST_PLACE;
				end else begin
					do_push = 1'b1;
					ld_res  = 1'b1;
					state_d = ST_RESULT;
				end
			end
			ST_PLACE: begin
				mem_we  = 1'b1;
				do_push = 1'b1;
				ld_res  = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || m_axis_tready) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Queue bookkeeping: head, tail and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q  <= ptr_inc(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (do_pop) begin
				head_q  <= ptr_inc(head_q);
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Walk pointers, the pending entry and the held result.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= in_kind;
			new_q  <= in_entry;
		end
		if (ld_walk) begin
			wr_ptr_q <= tail_q;
			rd_ptr_q <= ptr_dec(ptr_dec(tail_q));
			lvl_q    <= PW'(count_q - 1'b1);
		end else if (step_walk) begin
			wr_ptr_q <= ptr_dec(wr_ptr_q);
			rd_ptr_q <= ptr_dec(rd_ptr_q);
			lvl_q    <= lvl_q - 1'b1;
		end
		if (ld_res)
			res_q <= res_d;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ld_out)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_data_q <= {4'b0, 5'(count_q), res_q.head.mins, res_q.head.prio,
				       res_q.head.tag};
			out_user_q <= {res_q.full_res, res_q.found};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// Expected tail position from head and fill count, for checking.
	logic [PW:0]   tail_sum;
	logic [PW-1:0] tail_calc;
	assign tail_sum  = {1'b0, head_q} + (PW+1)'(count_q);
	assign tail_calc = (tail_sum >= (PW+1)'(QUEUE_DEPTH)) ?
			   PW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);

	// The fill count never passes the buffer depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("fill count beyond queue depth");

	// Between operations the tail sits count slots after the head.
	a_tail_track: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> tail_q == tail_calc)
		else $error("tail pointer out of step with head and count");

	// A walk that places the new entry behind a stored one grows the queue by exactly one entry.
	a_walk_push: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK && state_d == ST_RESULT |=> count_q == $past(count_q) + 1'b1)
		else $error("insert walk did not add one entry");

	// A new result beat only appears after the result state.
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_RESULT)
		else $error("result beat raised outside the result state");

	// A result never reports both a found head and a rejected insert.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("found and full flags both set");

endmodule

// ===== bench/tb_severity_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Severity priority queue unit testbench
// Drives insert, pop, peek and no-op beats into the queue and checks every
// result beat against a sorted-list model of the queue kept in the bench.
// Directed tests cover the empty queue, the clock time extremes, equal keys
// and the full queue. Random traffic then fills and drains the queue many
// times, with random gaps on both streams and one stretch without gaps.
// ----------------------------------------------------------------------------
module tb_severity_priority_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int QUEUE_DEPTH      = 16;
	localparam int HALF_DAY_HOURS   = 12;
	localparam int MINUTES_PER_HOUR = 60;
	localparam int RANDOM_ITEMS     = 1300;
	localparam int IDLE_PERCENT     = 22;
	localparam int SETTLE_CYCLES    = QUEUE_DEPTH + 8;
	localparam int STALL_LIMIT      = 5000;

	// One entry as the queue holds it.
	typedef struct {
		logic [7:0]  tag;
		logic [3:0]  prio;
		logic [10:0] mins;
	} stored_entry_t;

	// Fields of one result beat.
	typedef struct {
		logic        found;
		logic        full_res;
		logic [7:0]  tag;
		logic [3:0]  prio;
		logic [10:0] mins;
		logic [4:0]  occupancy;
	} queue_outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// tdata: entry_tag[7:0], clock_hour[11:8], clock_minute[17:12],
	//        is_pm[18], priority_req[22:19], zero pad[23]
	logic [23:0] s_axis_tdata = '0;
	// tuser: kind[1:0]
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// tdata: head_tag[7:0], head_priority[11:8], head_minutes[22:12],
	//        occupancy[27:23], zero pad[31:28]
	logic [31:0] m_axis_tdata;
	// tuser: found[0], full_res[1]
	logic [1:0]  m_axis_tuser;

	stored_entry_t  sorted_entries[$];
	queue_outcome_t pending_outcomes[$];
	int             error_count = 0;
	int             quiet_cycles = 0;
	logic           steady_flow = 1'b0;

	severity_priority_queue_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Converts a 12-hour clock time to minutes since midnight, out-of-range
	// hours and minutes included.
	function automatic logic [10:0] clock_to_minutes(input logic [3:0] hour,
							 input logic [5:0] minute,
							 input logic       pm);
		int h;
		h = hour;
		if (pm) begin
			if (h != HALF_DAY_HOURS)
				h = h + HALF_DAY_HOURS;
		end else if (h == HALF_DAY_HOURS) begin
			h = 0;
		end
		return 11'(h * MINUTES_PER_HOUR + minute);
	endfunction

	// Applies one operation to the sorted list and returns the result beat.
	function automatic queue_outcome_t apply_queue_op(input kind_t kind,
							  input logic [23:0] data);
		queue_outcome_t outcome;
		stored_entry_t  fresh;
		int             pos;
		outcome = '{found: 1'b0, full_res: 1'b0, tag: '0, prio: '0, mins: '0,
			    occupancy: '0};
		case (kind)
			KIND_INSERT: begin
				if (sorted_entries.size() >= QUEUE_DEPTH) begin
					outcome.full_res = 1'b1;
				end else begin
					fresh.tag  = data[7:0];
					fresh.prio = data[22:19];
					fresh.mins = clock_to_minutes(data[11:8], data[17:12], data[18]);
					// Walk past every entry that is not beaten by the new one,
					// so equal keys queue up behind those already stored.
					pos = 0;
					while (pos < sorted_entries.size() &&
					       !(fresh.prio > sorted_entries[pos].prio ||
						 (fresh.prio == sorted_entries[pos].prio &&
						  fresh.mins < sorted_entries[pos].mins)))
						pos++;
					sorted_entries.insert(pos, fresh);
				end
			end
			KIND_POP, KIND_PEEK: begin
				if (sorted_entries.size() > 0) begin
					outcome.found = 1'b1;
					outcome.tag   = sorted_entries[0].tag;
					outcome.prio  = sorted_entries[0].prio;
					outcome.mins  = sorted_entries[0].mins;
					if (kind == KIND_POP)
						void'(sorted_entries.pop_front());
				end
			end
			default: begin
			end
		endcase
		outcome.occupancy = 5'(sorted_entries.size());
		return outcome;
	endfunction

	// Sends one beat, with a random gap ahead of it unless traffic is steady.
	// The expected result is worked out at the edge that accepts the beat.
	task automatic send_op(input kind_t kind, input logic [7:0] tag,
			       input logic [3:0] hour, input logic [5:0] minute,
			       input logic pm, input logic [3:0] prio);
		logic [23:0] data;
		data = {1'b0, prio, pm, minute, hour, tag};
		while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_outcomes.push_back(apply_queue_op(kind, data));
	endtask

	task automatic send_head_op(input kind_t kind);
		send_op(kind, 8'($urandom), 4'($urandom), 6'($urandom), 1'($urandom),
			4'($urandom));
	endtask

	// A pop, a peek and a no-op on an empty queue.
	task automatic test_empty_queue();
		send_op(KIND_POP, 8'hFF, 4'hF, 6'h3F, 1'b1, 4'hF);
		send_op(KIND_PEEK, 8'h00, 4'h0, 6'h00, 1'b0, 4'h0);
		send_op(KIND_NOP, 8'h5A, 4'hC, 6'h2A, 1'b1, 4'h9);
	endtask

	// Fills the queue with the clock time extremes and equal keys, then tries
	// one insert too many.
	task automatic test_fill_to_capacity();
		send_op(KIND_INSERT, 8'h00, 4'd12, 6'd0, 1'b0, 4'd0);
		send_op(KIND_INSERT, 8'hFF, 4'd12, 6'd0, 1'b1, 4'd15);
		send_op(KIND_INSERT, 8'hA5, 4'd11, 6'd59, 1'b1, 4'd15);
		send_op(KIND_INSERT, 8'h5A, 4'd0, 6'd0, 1'b1, 4'd15);
		send_op(KIND_INSERT, 8'h3C, 4'd15, 6'd63, 1'b1, 4'd7);
		send_op(KIND_INSERT, 8'h11, 4'd15, 6'd63, 1'b0, 4'd7);
		send_op(KIND_INSERT, 8'h22, 4'd0, 6'd0, 1'b0, 4'd7);
		send_op(KIND_INSERT, 8'h33, 4'd1, 6'd0, 1'b0, 4'd0);
		send_op(KIND_INSERT, 8'h44, 4'd12, 6'd59, 1'b0, 4'd0);
		send_op(KIND_INSERT, 8'h55, 4'd1, 6'd0, 1'b0, 4'd0);
		for (int i = 0; i < QUEUE_DEPTH - 10; i++)
			send_op(KIND_INSERT, 8'($urandom), 4'($urandom_range(1, 12)),
				6'($urandom_range(0, 59)), 1'($urandom), 4'($urandom_range(5, 10)));
		send_op(KIND_INSERT, 8'h99, 4'd1, 6'd0, 1'b0, 4'd15);
		send_op(KIND_PEEK, 8'h00, 4'h0, 6'h00, 1'b0, 4'h0);
	endtask

	// Removes the head twice and looks at the new head.
	task automatic test_head_removal();
		send_head_op(KIND_POP);
		send_head_op(KIND_POP);
		send_head_op(KIND_PEEK);
		send_head_op(KIND_NOP);
	endtask

	// Random traffic in runs that lean towards inserts or towards removals,
	// so that the queue fills and empties again and again.
	task automatic test_random_traffic();
		int          sent;
		int          run_length;
		int          insert_share;
		int          pick;
		logic [3:0]  hour;
		logic [5:0]  minute;
		logic [3:0]  prio;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			run_length = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: insert_share = 85;
				1: insert_share = 50;
				default: insert_share = 15;
			endcase
			for (int i = 0; i < run_length && sent < RANDOM_ITEMS; i++) begin
				steady_flow <= (sent >= 450 && sent < 700);
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					send_head_op(KIND_NOP);
				end else if (pick < 3 + insert_share) begin
					// Narrow keys often, so that equal keys meet in the queue.
					if ($urandom_range(0, 99) < 30) begin
						prio   = $urandom_range(0, 1) ? 4'd3 : 4'd9;
						hour   = 4'($urandom_range(1, 2));
						minute = 6'($urandom_range(0, 1));
					end else begin
						prio   = 4'($urandom);
						hour   = ($urandom_range(0, 99) < 80) ?
							 4'($urandom_range(1, 12)) : 4'($urandom);
						minute = ($urandom_range(0, 99) < 85) ?
							 6'($urandom_range(0, 59)) : 6'($urandom);
					end
					send_op(KIND_INSERT, 8'($urandom), hour, minute, 1'($urandom),
						prio);
				end else if ($urandom_range(0, 99) < 70) begin
					send_head_op(KIND_POP);
				end else begin
					send_head_op(KIND_PEEK);
				end
				sent++;
			end
		end
		steady_flow <= 1'b0;
	endtask

	// Result receiver: random back-pressure except during steady traffic.
	always @(posedge clk)
		m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);

	task automatic check_field(input string name, input int expected,
				   input int actual);
		if (expected != actual) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			error_count++;
		end
	endtask

	// Compares each accepted result beat with the oldest expectation.
	always @(posedge clk) begin
		queue_outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result beat with no expectation waiting");
				error_count++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("found", want.found, m_axis_tuser[0]);
				check_field("full_res", want.full_res, m_axis_tuser[1]);
				check_field("head_tag", want.tag, m_axis_tdata[7:0]);
				check_field("head_priority", want.prio, m_axis_tdata[11:8]);
				check_field("head_minutes", want.mins, m_axis_tdata[22:12]);
				check_field("occupancy", want.occupancy, m_axis_tdata[27:23]);
			end
		end
	end

	// Watchdog: ends the run when no beat moves for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("severity_priority_queue_unit regression: fail");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_fill_to_capacity();
		test_head_removal();
		test_random_traffic();
		s_axis_tvalid <= 1'b0;
		while (pending_outcomes.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_outcomes.size() == 0)
			$display("severity_priority_queue_unit regression: pass");
		else
			$display("severity_priority_queue_unit regression: fail");
		$finish;
	end

endmodule

// ===== severity_priority_queue_unit.f =====
rtl/core/spq_pkg.sv
rtl/core/severity_priority_queue_unit.sv
bench/tb_severity_priority_queue_unit.sv
